FILE: hw/rtl/cq_pkg.sv
// cq_pkg: command codes, status codes, controller states and the
// command/status bundles shared by the circular queue modules
// no dependencies
package cq_pkg;

    localparam int DATA_W = 32;

    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_PUSH = 2'd0;
    localparam cmd_code_t CMD_POP  = 2'd1;
    localparam cmd_code_t CMD_SHOW = 2'd2;

    typedef logic [1:0] status_code_t;
    localparam status_code_t STAT_OK    = 2'd0;
    localparam status_code_t STAT_FULL  = 2'd1;
    localparam status_code_t STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SHOW
    } state_t;

    typedef struct packed {
        logic         ld_out;
        logic         sel_mem;
        status_code_t out_status;
        logic         out_last;
        logic         do_push;
        logic         do_pop;
        logic         rd_en;
        logic         rd_next;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic show_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hw/rtl/circular_queue.sv
// circular_queue: ring-buffer queue of signed 32-bit words, top level
// depends on cq_pkg, cq_ctrl, cq_dp
//
// input channel (in_valid/in_ready) carries one command per transfer:
// cmd push appends push_value, pop removes the oldest word, show lists
// every stored word oldest first; unused code 3 gives no result
// output channel (out_valid/out_ready) carries status, data_out and last;
// last marks the final result of a command
// push, and any command answered full or empty: one result, registered in the
// cycle after the transfer; the next command can be taken as the receiver takes it
// pop: one result, read through the registered read port of the slot memory and
// then the result register in S_POP; next command taken once back in S_IDLE
// show of n words: n results through the same read port, the first as for pop,
// then one per cycle while the output is not stalled; next command taken in S_IDLE
// reset: queue empty, head at slot zero, no result pending; slot contents
// are not cleared and need no clearing pass
// receiver stall: the result register holds and the block stops taking
// commands or stepping a show until the pending result is transferred
module circular_queue #(
    parameter int DEPTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic signed [31:0]        push_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic signed [31:0]        data_out,
    output logic                      last
);

    cq_pkg::dp_cmd_t  dp_cmd;
    cq_pkg::dp_stat_t dp_stat;

    cq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    cq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .data_out   (data_out),
        .last       (last)
    );

endmodule

FILE: hw/rtl/cq_dp.sv
// cq_dp: slot memory, head and occupancy registers, show index and result register
// depends on cq_pkg; driven by cq_ctrl
module cq_dp #(
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cq_pkg::dp_cmd_t          dp_cmd,
    output cq_pkg::dp_stat_t         dp_stat,
    input  logic [cq_pkg::DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [cq_pkg::DATA_W-1:0] data_out,
    output logic                     last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [cq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [cq_pkg::DATA_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] head_inc;

    logic                      out_valid_reg;
    cq_pkg::status_code_t      status_reg;
    logic [cq_pkg::DATA_W-1:0] data_reg;
    logic                      last_reg;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign rd_idx   = dp_cmd.rd_next ? (idx_reg + IDX_W'(1)) : '0;
    assign rd_addr  = wrap_add(head_reg, rd_idx);
    assign wr_addr  = wrap_add(head_reg, occ_reg[IDX_W-1:0]);
    assign head_inc = wrap_add(head_reg, IDX_W'(1));

    assign dp_stat.full      = (occ_reg == CNT_W'(DEPTH));
    assign dp_stat.empty     = (occ_reg == '0);
    assign dp_stat.show_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg);
    assign dp_stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        if (dp_cmd.do_push)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (dp_cmd.do_pop)
        begin
            occ_next  = occ_reg - CNT_W'(1);
            head_next = (occ_reg == CNT_W'(1)) ? '0 : head_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            if (dp_cmd.rd_en)
            begin
                idx_reg <= rd_idx;
            end
            if (dp_cmd.ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // slot memory and registered read port
    always_ff @(posedge clk)
    begin
        if (dp_cmd.do_push)
        begin
            mem[wr_addr] <= push_value;
        end
        if (dp_cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.ld_out)
        begin
            status_reg <= dp_cmd.out_status;
            data_reg   <= dp_cmd.sel_mem ? rd_data_reg : '0;
            last_reg   <= dp_cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (head_reg == '0))
        else $error("head not reset on empty queue");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.do_push |-> !dp_stat.full && !dp_cmd.do_pop)
        else $error("push into full queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !dp_cmd.ld_out)
        else $error("result register overwritten while stalled");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.do_pop |-> !dp_stat.empty && dp_cmd.sel_mem)
        else $error("pop from empty queue");
`endif

endmodule

FILE: hw/rtl/cq_ctrl.sv
// cq_ctrl: command decode and sequencing of pop and show reads
// depends on cq_pkg; drives cq_dp
module cq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  cq_pkg::dp_stat_t     dp_stat,
    output cq_pkg::dp_cmd_t      dp_cmd
);

    cq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        dp_cmd     = '0;
        unique case (state_reg)
            cq_pkg::S_IDLE:
            begin
                in_ready = dp_stat.out_free;
                if (in_valid && dp_stat.out_free)
                begin
                    unique case (cmd)
                        cq_pkg::CMD_PUSH:
                        begin
                            dp_cmd.ld_out     = 1'b1;
                            dp_cmd.out_last   = 1'b1;
                            dp_cmd.out_status = dp_stat.full ? cq_pkg::STAT_FULL
                                                             : cq_pkg::STAT_OK;
                            dp_cmd.do_push    = !dp_stat.full;
                        end
                        cq_pkg::CMD_POP, cq_pkg::CMD_SHOW:
                        begin
                            if (dp_stat.empty)
                            begin
                                dp_cmd.ld_out     = 1'b1;
                                dp_cmd.out_last   = 1'b1;
                                dp_cmd.out_status = cq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.rd_en = 1'b1;
                                state_next   = (cmd == cq_pkg::CMD_POP) ? cq_pkg::S_POP
                                                                        : cq_pkg::S_SHOW;
                            end
                        end
                        default:
                        begin
                            // unused code: dropped without a result
                        end
                    endcase
                end
            end
            cq_pkg::S_POP:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.ld_out     = 1'b1;
                    dp_cmd.sel_mem    = 1'b1;
                    dp_cmd.out_status = cq_pkg::STAT_OK;
                    dp_cmd.out_last   = 1'b1;
                    dp_cmd.do_pop     = 1'b1;
                    state_next        = cq_pkg::S_IDLE;
                end
            end
            cq_pkg::S_SHOW:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.ld_out     = 1'b1;
                    dp_cmd.sel_mem    = 1'b1;
                    dp_cmd.out_status = cq_pkg::STAT_OK;
                    dp_cmd.out_last   = dp_stat.show_last;
                    if (dp_stat.show_last)
                    begin
                        state_next = cq_pkg::S_IDLE;
                    end
                    else
                    begin
                        dp_cmd.rd_en   = 1'b1;
                        dp_cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cq_pkg::S_IDLE;
            end
        endcase
    end

endmodule
